FILE: hw/rtl/rwrp_pkg.sv
package rwrp_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int OP_W        = 2;
   localparam int STEP_W      = 32;
   localparam int RATE_W      = 32;
   localparam int SUM_W       = 40;
   localparam int FRAC_W      = 32;
   localparam int NUM_W       = RATE_W + 16;
   localparam int DIV_CNT_W   = $clog2(NUM_W);

   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_W-1:0] OP_PICK  = 2'd2;

   localparam logic [RATE_W-1:0] RATE_MAX        = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX         = '1;
   localparam logic [RATE_W-1:0] RATE_FACTOR_RST = 32'd65536;

   typedef struct packed {
      logic              valid;
      logic [RATE_W-1:0] rate;
      logic [IDX_W-1:0]  idx;
   } cell_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: hw/rtl/rwrp_if.sv
interface rwrp_req_if;
   import rwrp_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [7:0]        entry_index;
   logic [STEP_W-1:0] step_length;
   logic [8:0]        entry_count;
   logic [FRAC_W-1:0] random_fraction;
   modport source (output valid, op, entry_index, step_length, entry_count, random_fraction,
                   input ready);
   modport sink   (input valid, op, entry_index, step_length, entry_count, random_fraction,
                   output ready);
endinterface

interface rwrp_rsp_if;
   import rwrp_pkg::*;
   logic             valid;
   logic             ready;
   logic [7:0]       picked_index;
   logic [SUM_W-1:0] total_rate;
   modport source (output valid, picked_index, total_rate, input ready);
   modport sink   (input valid, picked_index, total_rate, output ready);
endinterface

interface rwrp_csr_if;
   import rwrp_pkg::*;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] rate_factor;
   modport source (output valid, rate_factor, input ready);
   modport sink   (input valid, rate_factor, output ready);
endinterface

FILE: hw/rtl/rwrp_ram.sv
module rwrp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hw/rtl/rwrp_div.sv
module rwrp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rwrp_pkg::RATE_W-1:0] factor,
   input  logic [rwrp_pkg::STEP_W-1:0] step,
   output logic                       done,
   output logic [rwrp_pkg::RATE_W-1:0] rate
);
   import rwrp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [STEP_W:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]    den_ff, den_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [STEP_W:0]      rem_sh;
   logic                 qbit;
   logic [NUM_W-1:0]     q_full;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rate_in = rate_ff;
      // shift-subtract, one quotient bit a cycle
      rem_sh  = {rem_ff[STEP_W-1:0], num_ff[NUM_W-1]};
      qbit    = (rem_sh >= {1'b0, den_ff});
      q_full  = {num_ff[NUM_W-2:0], qbit};
      if (start) begin
         if (step == '0) begin
            rate_in = RATE_MAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            num_in  = {factor, 16'd0};
            rem_in  = '0;
            den_in  = step;
            cnt_in  = DIV_CNT_W'(NUM_W - 1);
         end
      end else if (busy_ff) begin
         rem_in = qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         num_in = q_full;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            rate_in = (|q_full[NUM_W-1:RATE_W]) ? RATE_MAX : q_full[RATE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      rate_ff <= rate_in;
   end

   assign done = done_ff;
   assign rate = rate_ff;
endmodule

FILE: hw/rtl/rwrp_cell.sv
module rwrp_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rwrp_pkg::cell_ctl_type ctl,
   input  rwrp_pkg::cell_type     key,
   input  rwrp_pkg::cell_type     left_d,
   input  logic                   left_gt,
   input  rwrp_pkg::cell_type     right_d,
   output rwrp_pkg::cell_type     cell_q,
   output logic                   gt
);
   import rwrp_pkg::*;

   cell_type cell_ff, cell_in;

   // empty cells count as larger, so inserts fill from the front
   assign gt = !cell_ff.valid || (cell_ff.rate > key.rate);

   always_comb begin
      cell_in = cell_ff;
      if (ctl.clear) begin
         cell_in.valid = 1'b0;
      end else if (ctl.insert && gt) begin
         cell_in = left_gt ? left_d : key;
      end else if (ctl.shift) begin
         cell_in = right_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_q = cell_ff;
endmodule

FILE: hw/rtl/rate_weighted_random_pick_top.sv
// Weighted random pick over up to 256 entries.
// req_ch beats carry an op: load (store entry_index's step_length), build
// (entry_count entries: rate = rate_factor/step_length in Q16.16, sort by
// ascending rate, form running sums), or pick (scale random_fraction by the
// total and return the first sorted entry whose running sum reaches it).
// Only a pick produces an rsp_ch beat: picked_index and total_rate.
// csr_ch writes rate_factor; always ready, it takes effect at the next divide start.
// A load is a single write to the step RAM. A build handles each entry in turn
// (a step read, a 48-step shift-subtract divider per rate, then one insert into
// the sorting row of cells) and then drains the row into the sum RAM entry by
// entry. The length of a pick is set by the binary search: each probe needs a
// registered read of the sum RAM.
// One op is in flight at a time; req_ch.ready is high only between ops.
// A finished pick sits in the output register; if rsp_ch stalls, the next
// op is still accepted and the next pick waits for the register to drain.
// Reset (synchronous, active high) sets rate_factor to 1.0, entry count to
// one and empties the cell row; RAM contents are undefined until written.
module rate_weighted_random_pick_top (
   input logic       clock,
   input logic       reset,
   rwrp_req_if.sink  req_ch,
   rwrp_rsp_if.source rsp_ch,
   rwrp_csr_if.sink  csr_ch
);
   import rwrp_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_BRD   = 4'd1;  // issue step read
   localparam logic [3:0] ST_BDIV  = 4'd2;  // step data back, start divide
   localparam logic [3:0] ST_BWAIT = 4'd3;  // divide running, insert when done
   localparam logic [3:0] ST_SUM   = 4'd4;  // drain row into order/sum RAMs
   localparam logic [3:0] ST_PTOT  = 4'd5;  // read total
   localparam logic [3:0] ST_PMUL  = 4'd6;  // partial products
   localparam logic [3:0] ST_PVAL  = 4'd7;  // scaled value
   localparam logic [3:0] ST_SRD   = 4'd8;  // probe read
   localparam logic [3:0] ST_SCMP  = 4'd9;  // probe compare
   localparam logic [3:0] ST_ORD   = 4'd10; // read original index
   localparam logic [3:0] ST_OWT   = 4'd11; // load output register

   logic [3:0]        state_ff, state_in;
   logic [RATE_W-1:0] factor_ff, factor_in;
   logic [CNT_W-1:0]  active_ff, active_in;
   logic [CNT_W-1:0]  ctr_ff, ctr_in;       // build / drain position
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  phi_ff, phi_in;
   logic [63:0]       plo_ff, plo_in;
   logic [SUM_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  mid_ff, mid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_idx_ff, rsp_idx_in;
   logic [SUM_W-1:0]  rsp_total_ff, rsp_total_in;

   logic              accept;
   logic [CNT_W-1:0]  count_clamp;
   logic [SUM_W:0]    acc_sum;
   logic [IDX_W-1:0]  last_idx;

   // step RAM
   logic              step_we;
   logic [STEP_W-1:0] step_rdata;
   // order / sum RAMs
   logic              drain_we;
   logic [IDX_W-1:0]  sum_raddr;
   logic [IDX_W-1:0]  sum_raddr_q;
   logic [SUM_W-1:0]  sum_rdata;
   logic [IDX_W-1:0]  ord_rdata;
   // divider
   logic              div_start;
   logic              div_done;
   logic [RATE_W-1:0] div_rate;
   // cell row
   cell_ctl_type      row_ctl;
   cell_type          key;
   cell_type          cells [MAX_ENTRIES];
   logic              gts   [MAX_ENTRIES];

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign count_clamp = (req_ch.entry_count == '0) ? CNT_W'(1) :
                        (req_ch.entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) :
                        req_ch.entry_count;
   assign last_idx = IDX_W'(active_ff - 1'b1);
   assign acc_sum  = {1'b0, acc_ff} + {{(SUM_W - RATE_W + 1){1'b0}}, cells[0].rate};

   assign step_we   = accept && (req_ch.op == OP_LOAD);
   assign drain_we  = (state_ff == ST_SUM);
   assign sum_raddr = (state_ff == ST_PTOT) ? last_idx : mid_ff;
   assign div_start = (state_ff == ST_BDIV);

   assign key.valid = 1'b1;
   assign key.rate  = div_rate;
   assign key.idx   = ctr_ff[IDX_W-1:0];

   assign row_ctl.clear  = accept && (req_ch.op == OP_BUILD);
   assign row_ctl.insert = (state_ff == ST_BWAIT) && div_done;
   assign row_ctl.shift  = (state_ff == ST_SUM);

   always_comb begin
      state_in     = state_ff;
      factor_in    = (csr_ch.valid && csr_ch.ready) ? csr_ch.rate_factor : factor_ff;
      active_in    = active_ff;
      ctr_in       = ctr_ff;
      acc_in       = acc_ff;
      frac_in      = frac_ff;
      total_in     = total_ff;
      phi_in       = phi_ff;
      plo_in       = plo_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_total_in = rsp_total_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.op)
                  OP_BUILD: begin
                     active_in = count_clamp;
                     ctr_in    = '0;
                     acc_in    = '0;
                     state_in  = ST_BRD;
                  end
                  OP_PICK: begin
                     frac_in  = req_ch.random_fraction;
                     state_in = ST_PTOT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BRD:  state_in = ST_BDIV;
         ST_BDIV: state_in = ST_BWAIT;
         ST_BWAIT: begin
            if (div_done) begin
               ctr_in = ctr_ff + 1'b1;
               if (ctr_ff + 1'b1 == active_ff) begin
                  ctr_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_BRD;
               end
            end
         end
         ST_SUM: begin
            // saturating running sum of the sorted rates
            acc_in = acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
            ctr_in = ctr_ff + 1'b1;
            if (ctr_ff + 1'b1 == active_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_PTOT: state_in = ST_PMUL;
         ST_PMUL: begin
            total_in = sum_rdata;
            phi_in   = SUM_W'(frac_ff * sum_rdata[SUM_W-1:RATE_W]);
            plo_in   = frac_ff * sum_rdata[RATE_W-1:0];
            state_in = ST_PVAL;
         end
         ST_PVAL: begin
            val_in   = phi_ff + {{(SUM_W - 32){1'b0}}, plo_ff[63:32]};
            lo_in    = '0;
            hi_in    = last_idx;
            state_in = ST_SRD;
         end
         ST_SRD: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               state_in = ST_SCMP;
            end else begin
               state_in = ST_ORD;
            end
         end
         ST_SCMP: begin
            if (sum_rdata >= val_ff) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = ST_SRD;
         end
         ST_ORD: state_in = ST_OWT;
         ST_OWT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 8'(ord_rdata);
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // probe address: mid is registered in ST_SRD, so the read issued there uses mid_in
   assign sum_raddr_q = (state_ff == ST_SRD) ? mid_in : sum_raddr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= RATE_FACTOR_RST;
         active_ff    <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ctr_ff       <= ctr_in;
      acc_ff       <= acc_in;
      frac_ff      <= frac_in;
      total_ff     <= total_in;
      phi_ff       <= phi_in;
      plo_ff       <= plo_in;
      val_ff       <= val_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.picked_index = rsp_idx_ff;
   assign rsp_ch.total_rate   = rsp_total_ff;

   rwrp_ram #(.WIDTH(STEP_W), .DEPTH(MAX_ENTRIES)) u_step_ram (
      .clock (clock),
      .we    (step_we),
      .waddr (req_ch.entry_index[IDX_W-1:0]),
      .wdata (req_ch.step_length),
      .raddr (ctr_ff[IDX_W-1:0]),
      .rdata (step_rdata)
   );

   rwrp_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_order_ram (
      .clock (clock),
      .we    (drain_we),
      .waddr (ctr_ff[IDX_W-1:0]),
      .wdata (cells[0].idx),
      .raddr (lo_ff),
      .rdata (ord_rdata)
   );

   rwrp_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ENTRIES)) u_sum_ram (
      .clock (clock),
      .we    (drain_we),
      .waddr (ctr_ff[IDX_W-1:0]),
      .wdata (acc_in),
      .raddr (sum_raddr_q),
      .rdata (sum_rdata)
   );

   rwrp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .factor (factor_ff),
      .step   (step_rdata),
      .done   (div_done),
      .rate   (div_rate)
   );

   // Sorting row: cell 0 holds the smallest rate. An insert shifts every cell
   // holding a larger rate one place right; a drain shifts the row left.
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_row
      cell_type left_d;
      cell_type right_d;
      logic     left_gt;
      if (g == 0) begin : g_first
         assign left_d  = '0;
         assign left_gt = 1'b0;
      end else begin : g_mid
         assign left_d  = cells[g-1];
         assign left_gt = gts[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_next
         assign right_d = cells[g+1];
      end
      rwrp_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (row_ctl),
         .key     (key),
         .left_d  (left_d),
         .left_gt (left_gt),
         .right_d (right_d),
         .cell_q  (cells[g]),
         .gt      (gts[g])
      );
   end
endmodule
